@@ rtl/core/ehp_pkg.sv @@
// shared types, constants and decode tables for the e-ac-3 header parser
package ehp_pkg;

    localparam logic [15:0] SYNC_WORD      = 16'h0B77;
    localparam logic [12:0] MIN_FRAME      = 13'd7;
    localparam logic [19:0] TICKS_NUM      = 20'd720000;
    // ceil(2^24 / 3), exact for dividends below 2^23
    localparam logic [22:0] DIV3_MAGIC     = 23'd5592406;
    localparam int          DIV3_SHIFT     = 24;
    localparam int          Q_BITS         = 16;
    localparam int          DIV_STAGES     = Q_BITS;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_SYNC = 3'd1,
        ST_BAD_TYPE = 3'd2,
        ST_SHORT    = 3'd3,
        ST_BAD_RATE = 3'd4
    } t_status;

    // fields that ride along the pipeline untouched
    typedef struct packed {
        t_status     status;
        logic [12:0] frame_size;
        logic [15:0] sample_rate;
        logic [2:0]  channel_count;
    } t_item;

    // block-count control for the bit-rate divide
    typedef struct packed {
        logic half;
        logic div3;
    } t_blk;

    function automatic logic [15:0] rate_of(input logic [1:0] code);
        logic [15:0] r;
        unique case (code)
            2'd0:    r = 16'd48000;
            2'd1:    r = 16'd44100;
            2'd2:    r = 16'd32000;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] chan_of(input logic [2:0] acmod);
        logic [2:0] c;
        unique case (acmod)
            3'd0:    c = 3'd2;
            3'd1:    c = 3'd1;
            3'd2:    c = 3'd2;
            3'd3:    c = 3'd3;
            3'd4:    c = 3'd3;
            3'd5:    c = 3'd4;
            3'd6:    c = 3'd4;
            default: c = 3'd5;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/eac3_header_parser_core.sv @@
// e-ac-3 syncframe header parser, top level
// pipeline: a request passes 1 decode stage, 3 bit-rate stages and 16 divider
//   stages for the duration before its result strobe
// throughput: one request per cycle; busy is never raised, the 16-stage
//   divider pipeline sets the latency but not the rate
// reset: synchronous active-low reset clears all in-flight valid bits
module eac3_header_parser_core import ehp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [39:0] i_header_bits,
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic [12:0] o_frame_size,
    output logic [15:0] o_sample_rate,
    output logic [22:0] o_bit_rate,
    output logic [2:0]  o_channel_count,
    output logic [15:0] o_frame_ticks
);

    // request taken whenever start is high, the pipeline never backs up
    logic        take;

    logic        dec_valid;
    t_item       dec_item;
    t_blk        dec_blk;

    logic        rate_valid;
    t_item       rate_item;
    logic [22:0] rate_bits;
    logic [31:0] rate_numer;

    logic              div_valid;
    t_item             div_item;
    logic [22:0]       div_rate;
    logic [Q_BITS-1:0] div_quot;

    logic        ok;

    assign busy = 1'b0;
    assign take = start && !busy;

    // sync, type, size and rate checks plus table lookups
    ehp_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (take),
        .i_header_bits (i_header_bits),
        .o_valid       (dec_valid),
        .o_item        (dec_item),
        .o_blk         (dec_blk)
    );

    // bit rate = frame_size * rate / (32 * blocks), thirds by reciprocal multiply
    ehp_rate u_rate (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (dec_valid),
        .i_item     (dec_item),
        .i_blk      (dec_blk),
        .o_valid    (rate_valid),
        .o_item     (rate_item),
        .o_bit_rate (rate_bits),
        .o_numer    (rate_numer)
    );

    // ticks = frame_size * 720000 / bit rate; valid headers always fit 16 bits
    ehp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (rate_valid),
        .i_item     (rate_item),
        .i_divisor  (rate_bits),
        .i_numer    (rate_numer),
        .o_valid    (div_valid),
        .o_item     (div_item),
        .o_bit_rate (div_rate),
        .o_quot     (div_quot)
    );

    // fields past frame size only mean something on a good header
    assign ok              = div_item.status == ST_OK;
    assign o_strobe        = div_valid;
    assign o_status        = div_item.status;
    assign o_frame_size    = div_item.frame_size;
    assign o_sample_rate   = ok ? div_item.sample_rate : '0;
    assign o_bit_rate      = ok ? div_rate : '0;
    assign o_channel_count = ok ? div_item.channel_count : '0;
    assign o_frame_ticks   = ok ? div_quot : '0;

endmodule

@@ rtl/core/ehp_decode.sv @@
// first stage: field split, checks and table decode
module ehp_decode import ehp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [39:0] i_header_bits,
    output logic        o_valid,
    output t_item       o_item,
    output t_blk        o_blk
);

    logic        r_valid;
    t_item       r_item, n_item;
    t_blk        r_blk, n_blk;

    logic [15:0] sync;
    logic [1:0]  ftype, rcode, rcode2;
    logic [10:0] fcode;
    logic [2:0]  acmod;
    logic        lfe;
    logic [12:0] fsize;

    always_comb begin
        sync   = i_header_bits[39:24];
        ftype  = i_header_bits[23:22];
        fcode  = i_header_bits[18:8];
        rcode  = i_header_bits[7:6];
        rcode2 = i_header_bits[5:4];
        acmod  = i_header_bits[3:1];
        lfe    = i_header_bits[0];
        fsize  = {({1'b0, fcode} + 12'd1), 1'b0};

        n_item.frame_size    = fsize;
        n_item.channel_count = chan_of(acmod) + {2'b00, lfe};
        if (rcode == 2'd3) begin
            n_item.sample_rate = rate_of(rcode2) >> 1;
        end else begin
            n_item.sample_rate = rate_of(rcode);
        end
        n_blk.half = (rcode == 2'd3) || rcode2[0];
        n_blk.div3 = (rcode == 2'd3) || rcode2[1];

        priority if (sync != SYNC_WORD) begin
            n_item.status     = ST_BAD_SYNC;
            n_item.frame_size = '0;
        end else if (ftype == 2'd3) begin
            n_item.status = ST_BAD_TYPE;
        end else if (fsize < MIN_FRAME) begin
            n_item.status = ST_SHORT;
        end else if (rcode == 2'd3 && rcode2 == 2'd3) begin
            n_item.status = ST_BAD_RATE;
        end else begin
            n_item.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_item <= n_item;
        r_blk  <= n_blk;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_blk   = r_blk;

endmodule

@@ rtl/core/ehp_rate.sv @@
// three stages: products, shift and divide-by-three multiply, bit-rate select
module ehp_rate import ehp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    input  t_blk        i_blk,
    output logic        o_valid,
    output t_item       o_item,
    output logic [22:0] o_bit_rate,
    output logic [31:0] o_numer
);

    // stage a
    logic        r_a_valid;
    t_item       r_a_item;
    t_blk        r_a_blk;
    logic [28:0] r_a_prod, n_a_prod;
    logic [31:0] r_a_num, n_a_num;
    // stage b
    logic        r_b_valid;
    t_item       r_b_item;
    logic        r_b_div3;
    logic [22:0] r_b_x, n_b_x;
    logic [45:0] r_b_m, n_b_m;
    logic [31:0] r_b_num;
    // stage c
    logic        r_c_valid;
    t_item       r_c_item;
    logic [22:0] r_c_rate, n_c_rate;
    logic [31:0] r_c_num;

    always_comb begin
        n_a_prod = {16'd0, i_item.frame_size} * {13'd0, i_item.sample_rate};
        // 4096 * 720000 still fits 32 bits
        n_a_num  = {19'd0, i_item.frame_size} * {12'd0, TICKS_NUM};
        // divide by 32 or 64; valid products stay below 2^28
        n_b_x    = r_a_blk.half ? r_a_prod[28:6] : r_a_prod[27:5];
        n_b_m    = {23'd0, n_b_x} * {23'd0, DIV3_MAGIC};
        n_c_rate = r_b_div3 ? {1'b0, r_b_m[45:DIV3_SHIFT]} : r_b_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
        r_a_item <= i_item;
        r_a_blk  <= i_blk;
        r_a_prod <= n_a_prod;
        r_a_num  <= n_a_num;
        r_b_item <= r_a_item;
        r_b_div3 <= r_a_blk.div3;
        r_b_x    <= n_b_x;
        r_b_m    <= n_b_m;
        r_b_num  <= r_a_num;
        r_c_item <= r_b_item;
        r_c_rate <= n_c_rate;
        r_c_num  <= r_b_num;
    end

    assign o_valid    = r_c_valid;
    assign o_item     = r_c_item;
    assign o_bit_rate = r_c_rate;
    assign o_numer    = r_c_num;

endmodule

@@ rtl/core/ehp_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module ehp_div import ehp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_item             i_item,
    input  logic [22:0]       i_divisor,
    input  logic [31:0]       i_numer,
    output logic              o_valid,
    output t_item             o_item,
    output logic [22:0]       o_bit_rate,
    output logic [Q_BITS-1:0] o_quot
);

    logic              r_valid [DIV_STAGES];
    t_item             r_item  [DIV_STAGES];
    logic [22:0]       r_div   [DIV_STAGES];
    logic [22:0]       r_rem   [DIV_STAGES];
    logic [Q_BITS-1:0] r_low   [DIV_STAGES];
    logic [Q_BITS-1:0] r_quot  [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_stage
            logic              a_valid;
            t_item             a_item;
            logic [22:0]       a_div, a_rem, n_rem;
            logic [Q_BITS-1:0] a_low, a_quot;
            logic [23:0]       t;
            logic              ge;

            if (k == 0) begin : g_first
                // quotient fits in Q_BITS, so the upper half is below the divisor
                assign a_valid = i_valid;
                assign a_item  = i_item;
                assign a_div   = i_divisor;
                assign a_rem   = {7'd0, i_numer[31:Q_BITS]};
                assign a_low   = i_numer[Q_BITS-1:0];
                assign a_quot  = '0;
            end else begin : g_next
                assign a_valid = r_valid[k-1];
                assign a_item  = r_item[k-1];
                assign a_div   = r_div[k-1];
                assign a_rem   = r_rem[k-1];
                assign a_low   = r_low[k-1];
                assign a_quot  = r_quot[k-1];
            end

            always_comb begin
                t     = {a_rem, a_low[Q_BITS-1]};
                ge    = t >= {1'b0, a_div};
                n_rem = ge ? 23'(t - {1'b0, a_div}) : t[22:0];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else begin
                    r_valid[k] <= a_valid;
                end
                r_item[k] <= a_item;
                r_div[k]  <= a_div;
                r_rem[k]  <= n_rem;
                r_low[k]  <= {a_low[Q_BITS-2:0], 1'b0};
                r_quot[k] <= {a_quot[Q_BITS-2:0], ge};
            end
        end
    endgenerate

    assign o_valid    = r_valid[DIV_STAGES-1];
    assign o_item     = r_item[DIV_STAGES-1];
    assign o_bit_rate = r_div[DIV_STAGES-1];
    assign o_quot     = r_quot[DIV_STAGES-1];

endmodule

@@ rtl/core/ehp_checker.sv @@
// port-level checks for the header parser, bound to the top level
module ehp_checker import ehp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [2:0]  o_status,
    input logic [12:0] o_frame_size,
    input logic [15:0] o_sample_rate,
    input logic [22:0] o_bit_rate,
    input logic [2:0]  o_channel_count,
    input logic [15:0] o_frame_ticks
);

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##20 o_strobe)
        else $error("result strobe missing after request");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |->
        (o_sample_rate == 16'd0 && o_bit_rate == 23'd0 &&
         o_channel_count == 3'd0 && o_frame_ticks == 16'd0))
        else $error("derived fields nonzero on rejected header");

    a_sync_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_BAD_SYNC) |-> o_frame_size == 13'd0)
        else $error("frame size reported on bad sync");

    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_OK) |->
        (o_bit_rate != 23'd0 && o_frame_ticks != 16'd0 && o_frame_size >= MIN_FRAME))
        else $error("good header with zero rate or duration");

endmodule

bind eac3_header_parser_core ehp_checker u_ehp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_strobe        (o_strobe),
    .o_status        (o_status),
    .o_frame_size    (o_frame_size),
    .o_sample_rate   (o_sample_rate),
    .o_bit_rate      (o_bit_rate),
    .o_channel_count (o_channel_count),
    .o_frame_ticks   (o_frame_ticks)
);
